@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mmh assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mmh assertion failed");

// Next-cycle implication that stays armed through reset.
`define MMH_ASSERT_NXT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("mmh reset assertion failed");

`endif

@@ design/mmh_pkg.sv @@
// Shared codes, datapath micro-ops and status struct for the min-max heap.
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

    // request codes
    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_POP_MIN = 2'd1;
    localparam logic [1:0] REQ_POP_MAX = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // two children plus four grandchildren per trickle step
    localparam logic [2:0] SCAN_SLOTS = 3'd6;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SET_FULL,
        OP_SET_EMPTY,
        OP_INS_START,
        OP_INS_PAR,
        OP_GP_RD,
        OP_GP_CMP,
        OP_PUT,
        OP_POP_START,
        OP_POP_LOAD,
        OP_TD_INIT,
        OP_TD_SCAN,
        OP_TD_MOVE,
        OP_TD_CHILD,
        OP_TD_GRAND,
        OP_FIN0,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3
    } t_dp_op;

    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       pop_last;
        logic       gp_ok;
        logic       gp_better;
        logic       cand_ok;
        logic       best_is_pos;
        logic       best_is_child;
        logic       out_free;
    } t_dp_status;

endpackage

`default_nettype wire

@@ design/mmh_if.sv @@
// Request and response channel interfaces of the min-max heap.
`timescale 1ns / 1ps
`default_nettype none

interface mmh_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] key_in;

    modport source (output valid, req_type, key_in, input ready);
    modport sink   (input valid, req_type, key_in, output ready);
endinterface

interface mmh_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] popped_key;
    logic [1:0]  status;
    logic [6:0]  entry_total;
    logic [31:0] least_key;
    logic [31:0] greatest_key;

    modport source (output valid, popped_key, status, entry_total, least_key, greatest_key,
                    input ready);
    modport sink   (input valid, popped_key, status, entry_total, least_key, greatest_key,
                    output ready);
endinterface

`default_nettype wire

@@ design/min_max_heap_priority_queue.sv @@
// Top level of the min-max heap double-ended priority queue.
//
//   channel  dir  payload                                           handshake
//   i_req    in   req_type[1:0], key_in[31:0]                        valid/ready
//   o_rsp    out  popped_key, status, entry_total, least_key,        valid/ready
//                 greatest_key
//
// One request is worked at a time. An insert compares with its parent, then climbs
// grandparent levels (neither into an empty heap); a pop trickles down level by
// level, each level reading up to six entries through the single read port (no
// trickle when the last entry is popped); flagged or unknown requests go straight
// to the final readout. Reset clears the count and result valid; heap memory is
// not cleared, and only entries below the count are used.
// A new request is taken while a finished response waits; the last step of the
// next one stalls until the response register is free.
`timescale 1ns / 1ps
`default_nettype none

module min_max_heap_priority_queue #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mmh_req_if.sink    i_req,
    mmh_rsp_if.source  o_rsp
);
    import mmh_pkg::*;

    t_dp_op     op;      // micro-op issued by the controller each cycle
    t_dp_status st;      // datapath flags fed back for branching
    logic       in_ready;

    // controller: walks insert bubble-up, pop trickle-down and the final
    // readout of root and its children
    mmh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_st       (st),
        .o_in_ready (in_ready),
        .o_op       (op)
    );

    // datapath: heap memory, comparators, cached min/max and response register
    mmh_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_req_type     (i_req.req_type),
        .i_key_in       (i_req.key_in),
        .i_out_ready    (o_rsp.ready),
        .o_st           (st),
        .o_out_valid    (o_rsp.valid),
        .o_popped_key   (o_rsp.popped_key),
        .o_status       (o_rsp.status),
        .o_entry_total  (o_rsp.entry_total),
        .o_least_key    (o_rsp.least_key),
        .o_greatest_key (o_rsp.greatest_key)
    );

    assign i_req.ready = in_ready;

endmodule

`default_nettype wire

@@ design/mmh_ctrl.sv @@
// Sequencing state machine of the min-max heap.
`timescale 1ns / 1ps
`default_nettype none

module mmh_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire mmh_pkg::t_dp_status i_st,
    output logic                     o_in_ready,
    output mmh_pkg::t_dp_op          o_op
);
    import mmh_pkg::*;

    typedef enum logic [15:0] {
        S_IDLE      = 16'b0000_0000_0000_0001,
        S_DISPATCH  = 16'b0000_0000_0000_0010,
        S_INS_PAR   = 16'b0000_0000_0000_0100,
        S_INS_GP    = 16'b0000_0000_0000_1000,
        S_INS_GPC   = 16'b0000_0000_0001_0000,
        S_INS_PUT   = 16'b0000_0000_0010_0000,
        S_POP_LOAD  = 16'b0000_0000_0100_0000,
        S_TD_START  = 16'b0000_0000_1000_0000,
        S_TD_SCAN   = 16'b0000_0001_0000_0000,
        S_TD_DECIDE = 16'b0000_0010_0000_0000,
        S_TD_CHILD  = 16'b0000_0100_0000_0000,
        S_TD_GRAND  = 16'b0000_1000_0000_0000,
        S_FIN0      = 16'b0001_0000_0000_0000,
        S_FIN1      = 16'b0010_0000_0000_0000,
        S_FIN2      = 16'b0100_0000_0000_0000,
        S_FIN3      = 16'b1000_0000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_op    = OP_ACCEPT;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_st.req) inside
                    REQ_INSERT: begin
                        if (i_st.full) begin
                            o_op    = OP_SET_FULL;
                            n_state = S_FIN0;
                        end else begin
                            o_op    = OP_INS_START;
                            n_state = i_st.empty ? S_INS_PUT : S_INS_PAR;
                        end
                    end
                    REQ_POP_MIN, REQ_POP_MAX: begin
                        if (i_st.empty) begin
                            o_op    = OP_SET_EMPTY;
                            n_state = S_FIN0;
                        end else begin
                            o_op    = OP_POP_START;
                            n_state = i_st.pop_last ? S_FIN0 : S_POP_LOAD;
                        end
                    end
                    default: n_state = S_FIN0;
                endcase
            end
            S_INS_PAR: begin
                o_op    = OP_INS_PAR;
                n_state = S_INS_GP;
            end
            S_INS_GP: begin
                if (i_st.gp_ok) begin
                    o_op    = OP_GP_RD;
                    n_state = S_INS_GPC;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_GPC: begin
                o_op    = OP_GP_CMP;
                n_state = i_st.gp_better ? S_INS_GP : S_INS_PUT;
            end
            S_INS_PUT: begin
                o_op    = OP_PUT;
                n_state = S_FIN0;
            end
            S_POP_LOAD: begin
                o_op    = OP_POP_LOAD;
                n_state = S_TD_START;
            end
            S_TD_START: begin
                o_op    = OP_TD_INIT;
                n_state = S_TD_SCAN;
            end
            S_TD_SCAN: begin
                o_op = OP_TD_SCAN;
                if (!i_st.cand_ok) n_state = S_TD_DECIDE;
            end
            S_TD_DECIDE: begin
                o_op = OP_TD_MOVE;
                if (i_st.best_is_pos)        n_state = S_FIN0;
                else if (i_st.best_is_child) n_state = S_TD_CHILD;
                else                         n_state = S_TD_GRAND;
            end
            S_TD_CHILD: begin
                o_op    = OP_TD_CHILD;
                n_state = S_FIN0;
            end
            S_TD_GRAND: begin
                o_op    = OP_TD_GRAND;
                n_state = S_TD_START;
            end
            S_FIN0: begin
                o_op    = OP_FIN0;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                o_op    = OP_FIN1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                o_op    = OP_FIN2;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                o_op = OP_FIN3;
                if (i_st.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ design/mmh_datapath.sv @@
// Heap memory, working registers, comparators and result register.
`timescale 1ns / 1ps
`default_nettype none

module mmh_datapath #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mmh_pkg::t_dp_op     i_op,
    input  wire logic [1:0]          i_req_type,
    input  wire logic [31:0]         i_key_in,
    input  wire logic                i_out_ready,
    output mmh_pkg::t_dp_status      o_st,
    output logic                     o_out_valid,
    output logic [31:0]              o_popped_key,
    output logic [1:0]               o_status,
    output logic [6:0]               o_entry_total,
    output logic [31:0]              o_least_key,
    output logic [31:0]              o_greatest_key
);
    import mmh_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 3;

    typedef logic [KEY_WIDTH-1:0] t_key;

    function automatic logic min_level(input logic [AW-1:0] p);
        logic [AW:0] v;
        int          d;
        v = {1'b0, p} + (AW+1)'(1);
        d = 0;
        for (int i = 0; i <= AW; i++) begin
            if (v[i]) d = i;
        end
        return (d % 2) == 0;
    endfunction

    function automatic logic better(input t_key a, input t_key b, input logic maxlev);
        return (a < b) != maxlev;
    endfunction

    t_key r_mem [CAPACITY];
    t_key r_rdata;

    logic [1:0]    r_req;
    t_key          r_key;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_pos;
    t_key          r_cur;
    logic          r_maxlev;
    logic [AW-1:0] r_best;
    t_key          r_bestval;
    logic [2:0]    r_ci;
    logic          r_rv;
    logic [AW-1:0] r_cand;
    t_key          r_c0, r_c1, r_t0, r_t1;
    t_key          r_least, r_greatest;
    logic [1:0]    r_maxpos;
    t_key          r_popped;
    logic [1:0]    r_status;
    logic          r_out_valid;
    logic [31:0]   r_o_popped, r_o_least, r_o_greatest;
    logic [1:0]    r_o_status;
    logic [6:0]    r_o_total;

    logic [AW-1:0] parent, gp, cand_a, bpar, p_sel, rd_addr, wa;
    logic [XW-1:0] left, lg, cand_x;
    logic [CW-1:0] last;
    logic          pos_min, ins_swap, gp_better, cand_ok, best_is_pos, best_is_child;
    logic          par_better, out_free, we;
    t_key          parval, wd, fin_great;
    logic [1:0]    fin_maxpos;

    always_comb begin
        parent        = (r_pos - AW'(1)) >> 1;
        gp            = (parent - AW'(1)) >> 1;
        pos_min       = min_level(r_pos);
        ins_swap      = pos_min ? (r_rdata < r_cur) : (r_cur < r_rdata);
        gp_better     = better(r_cur, r_rdata, r_maxlev);
        left          = XW'({r_pos, 1'b1});
        lg            = XW'({r_pos, 2'b11});
        cand_x        = (r_ci < 3'd2) ? left + XW'(r_ci) : lg + XW'(r_ci) - XW'(2);
        cand_a        = cand_x[AW-1:0];
        cand_ok       = (r_ci < SCAN_SLOTS) && (cand_x < XW'(r_cnt));
        best_is_pos   = r_best == r_pos;
        best_is_child = (XW'(r_best) == left) || (XW'(r_best) == left + XW'(1));
        bpar          = (r_best - AW'(1)) >> 1;
        parval        = (XW'(bpar) == left) ? r_c0 : r_c1;
        par_better    = better(parval, r_cur, r_maxlev);
        last          = r_cnt - CW'(1);
        p_sel         = (r_req == REQ_POP_MIN) ? '0 : AW'(r_maxpos);
        out_free      = !r_out_valid || i_out_ready;
        if (r_cnt <= CW'(1))      fin_maxpos = 2'd0;
        else if (r_cnt == CW'(2)) fin_maxpos = 2'd1;
        else                      fin_maxpos = (r_t1 < r_rdata) ? 2'd2 : 2'd1;
        case (fin_maxpos)
            2'd0:    fin_great = r_t0;
            2'd1:    fin_great = r_t1;
            default: fin_great = r_rdata;
        endcase
    end

    // memory port selection
    always_comb begin
        rd_addr = '0;
        we      = 1'b0;
        wa      = r_pos;
        wd      = r_cur;
        case (i_op)
            OP_INS_START: rd_addr = AW'(last >> 1);
            OP_INS_PAR: begin
                we = ins_swap;
                wd = r_rdata;
            end
            OP_GP_RD:     rd_addr = gp;
            OP_GP_CMP: begin
                we = gp_better;
                wd = r_rdata;
            end
            OP_PUT:       we = 1'b1;
            OP_POP_START: rd_addr = AW'(last);
            OP_TD_SCAN:   rd_addr = cand_a;
            OP_TD_MOVE: begin
                we = 1'b1;
                wd = best_is_pos ? r_cur : r_bestval;
            end
            OP_TD_CHILD: begin
                we = 1'b1;
                wa = r_best;
            end
            OP_TD_GRAND: begin
                we = par_better;
                wa = bpar;
            end
            OP_FIN1:      rd_addr = AW'(1);
            OP_FIN2:      rd_addr = AW'(2);
            OP_FIN3:      rd_addr = AW'(2);
            default:      rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && i_op != OP_FIN3) r_out_valid <= 1'b0;
            case (i_op)
                OP_ACCEPT: begin
                    r_req    <= i_req_type;
                    r_key    <= KEY_WIDTH'(i_key_in);
                    r_popped <= '0;
                    r_status <= ST_OK;
                end
                OP_SET_FULL:  r_status <= ST_FULL;
                OP_SET_EMPTY: r_status <= ST_EMPTY;
                OP_INS_START: begin
                    r_pos <= AW'(r_cnt);
                    r_cur <= r_key;
                    r_cnt <= r_cnt + CW'(1);
                end
                OP_INS_PAR: begin
                    if (ins_swap) r_pos <= parent;
                    r_maxlev <= pos_min ? ins_swap : !ins_swap;
                end
                OP_GP_CMP: begin
                    if (gp_better) r_pos <= gp;
                end
                OP_POP_START: begin
                    r_popped <= (r_req == REQ_POP_MIN) ? r_least : r_greatest;
                    r_cnt    <= last;
                    r_pos    <= p_sel;
                end
                OP_POP_LOAD: begin
                    r_cur    <= r_rdata;
                    r_maxlev <= !pos_min;
                end
                OP_TD_INIT: begin
                    r_best    <= r_pos;
                    r_bestval <= r_cur;
                    r_ci      <= '0;
                    r_rv      <= 1'b0;
                end
                OP_TD_SCAN: begin
                    if (r_rv) begin
                        if (r_ci == 3'd1) r_c0 <= r_rdata;
                        if (r_ci == 3'd2) r_c1 <= r_rdata;
                        if (better(r_rdata, r_bestval, r_maxlev)) begin
                            r_best    <= r_cand;
                            r_bestval <= r_rdata;
                        end
                    end
                    if (cand_ok) begin
                        r_cand <= cand_a;
                        r_ci   <= r_ci + 3'd1;
                        r_rv   <= 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                    end
                end
                OP_TD_GRAND: begin
                    if (par_better) r_cur <= parval;
                    r_pos <= r_best;
                end
                OP_FIN1: r_t0 <= r_rdata;
                OP_FIN2: r_t1 <= r_rdata;
                OP_FIN3: begin
                    if (out_free) begin
                        r_least      <= r_t0;
                        r_greatest   <= fin_great;
                        r_maxpos     <= fin_maxpos;
                        r_out_valid  <= 1'b1;
                        r_o_popped   <= 32'(r_popped);
                        r_o_status   <= r_status;
                        r_o_total    <= 7'(r_cnt);
                        r_o_least    <= (r_cnt == '0) ? '0 : 32'(r_t0);
                        r_o_greatest <= (r_cnt == '0) ? '0 : 32'(fin_great);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_st.req           = r_req;
        o_st.full          = r_cnt == CW'(CAPACITY);
        o_st.empty         = r_cnt == '0;
        o_st.pop_last      = CW'(p_sel) == last;
        o_st.gp_ok         = r_pos >= AW'(3);
        o_st.gp_better     = gp_better;
        o_st.cand_ok       = cand_ok;
        o_st.best_is_pos   = best_is_pos;
        o_st.best_is_child = best_is_child;
        o_st.out_free      = out_free;
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_key   = r_o_popped;
    assign o_status       = r_o_status;
    assign o_entry_total  = r_o_total;
    assign o_least_key    = r_o_least;
    assign o_greatest_key = r_o_greatest;

endmodule

`default_nettype wire

@@ design/mmh_checker.sv @@
// Port-level checker for the min-max heap and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mmh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_popped_key,
    input wire logic [1:0]  i_status,
    input wire logic [6:0]  i_entry_total,
    input wire logic [31:0] i_least_key,
    input wire logic [31:0] i_greatest_key
);
    import mmh_pkg::*;

    `MMH_ASSERT_NXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `MMH_ASSERT_NXT_RST(a_rst_clears, i_clk, !i_rst_n, !i_out_valid)
    `MMH_ASSERT_IMP(a_empty_pop, i_clk, i_rst_n, i_out_valid && i_status == ST_EMPTY, i_entry_total == 7'd0 && i_popped_key == 32'd0)
    `MMH_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_entry_total == 7'd0, i_least_key == 32'd0 && i_greatest_key == 32'd0)
    `MMH_ASSERT_IMP(a_order, i_clk, i_rst_n, i_out_valid && i_entry_total != 7'd0, i_least_key <= i_greatest_key)

endmodule

bind min_max_heap_priority_queue mmh_checker u_mmh_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_popped_key   (o_rsp.popped_key),
    .i_status       (o_rsp.status),
    .i_entry_total  (o_rsp.entry_total),
    .i_least_key    (o_rsp.least_key),
    .i_greatest_key (o_rsp.greatest_key)
);

`default_nettype wire

@@ sim/tb_min_max_heap_priority_queue.sv @@
// Self-checking testbench for the min-max heap double-ended priority queue.
`timescale 1ns / 1ps
`default_nettype none

module tb_min_max_heap_priority_queue;
    import mmh_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic [31:0] popped_key;
        logic [1:0]  status;
        logic [6:0]  entry_total;
        logic [31:0] least_key;
        logic [31:0] greatest_key;
    } t_heap_result;

    logic i_clk;
    logic i_rst_n;

    mmh_req_if req_ch ();
    mmh_rsp_if rsp_ch ();

    min_max_heap_priority_queue #(.CAPACITY(DEPTH), .KEY_WIDTH(32)) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    // golden copy of the heap
    logic [31:0]  shadow_heap [DEPTH];
    int unsigned  shadow_count;
    t_heap_result pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int result_count;
    int insert_count;
    int pop_count;
    int flag_count;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit: about 1700 requests plus heavy stalls
    initial begin
        #60ms;
        $display("min_max_heap_priority_queue test failed");
        $finish;
    end

    function automatic bit is_min_level(int unsigned pos);
        int unsigned v;
        int unsigned depth;
        v = pos + 1;
        depth = 0;
        while (v > 1) begin
            v = v >> 1;
            depth++;
        end
        return depth[0] == 1'b0;
    endfunction

    // max levels prefer greater-or-equal, min levels strictly less
    function automatic bit outranks(logic [31:0] a, logic [31:0] b, bit on_max);
        return (a < b) != on_max;
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [31:0] t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic void climb_grand(int unsigned pos, bit on_max);
        int unsigned gp;
        while (pos >= 3) begin
            gp = (((pos - 1) >> 1) - 1) >> 1;
            if (!outranks(shadow_heap[pos], shadow_heap[gp], on_max)) return;
            swap_slots(gp, pos);
            pos = gp;
        end
    endfunction

    function automatic void sift_up(int unsigned pos);
        int unsigned par;
        if (pos == 0) return;
        par = (pos - 1) >> 1;
        if (is_min_level(pos)) begin
            if (shadow_heap[par] < shadow_heap[pos]) begin
                swap_slots(par, pos);
                climb_grand(par, 1'b1);
            end else begin
                climb_grand(pos, 1'b0);
            end
        end else begin
            if (shadow_heap[pos] < shadow_heap[par]) begin
                swap_slots(par, pos);
                climb_grand(par, 1'b0);
            end else begin
                climb_grand(pos, 1'b1);
            end
        end
    endfunction

    function automatic void sift_down(int unsigned pos);
        bit          on_max;
        int unsigned best;
        int unsigned left;
        int unsigned lg;
        int unsigned par;
        on_max = !is_min_level(pos);
        forever begin
            best = pos;
            left = 2 * pos + 1;
            lg = 2 * left + 1;
            if (left < shadow_count && outranks(shadow_heap[left], shadow_heap[best], on_max))
                best = left;
            if (left + 1 < shadow_count
                && outranks(shadow_heap[left + 1], shadow_heap[best], on_max))
                best = left + 1;
            for (int i = 0; i < 4 && lg + i < shadow_count; i++)
                if (outranks(shadow_heap[lg + i], shadow_heap[best], on_max)) best = lg + i;
            if (best == pos) return;
            swap_slots(pos, best);
            if (best - left <= 1) return;
            par = (best - 1) >> 1;
            if (outranks(shadow_heap[par], shadow_heap[best], on_max)) swap_slots(par, best);
            pos = best;
        end
    endfunction

    function automatic int unsigned greatest_slot();
        if (shadow_count <= 1) return 0;
        if (shadow_count == 2) return 1;
        return (shadow_heap[1] < shadow_heap[2]) ? 2 : 1;
    endfunction

    function automatic t_heap_result apply_request(logic [1:0] kind, logic [31:0] key);
        t_heap_result r;
        int unsigned  p;
        r = '0;
        if (kind == REQ_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                shadow_heap[shadow_count] = key;
                shadow_count++;
                sift_up(shadow_count - 1);
            end
        end else if (kind == REQ_POP_MIN || kind == REQ_POP_MAX) begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                p = (kind == REQ_POP_MIN) ? 0 : greatest_slot();
                r.popped_key = shadow_heap[p];
                if (p == shadow_count - 1) begin
                    shadow_count--;
                end else begin
                    shadow_heap[p] = shadow_heap[shadow_count - 1];
                    shadow_count--;
                    sift_down(p);
                end
            end
        end
        r.entry_total = shadow_count[6:0];
        if (shadow_count != 0) begin
            r.least_key = shadow_heap[0];
            r.greatest_key = shadow_heap[greatest_slot()];
        end
        return r;
    endfunction

    // one request; prediction is made at the accepting edge
    task automatic send_request(logic [1:0] kind, logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.key_in <= key;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.insert(pending_results.size(), apply_request(kind, key));
        if (kind == REQ_INSERT) insert_count++;
        else pop_count++;
        @(negedge i_clk);
    endtask

    // random response stalls, applied at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        else rsp_ch.ready <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_heap_result got;
        t_heap_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.popped_key, rsp_ch.status, rsp_ch.entry_total,
                   rsp_ch.least_key, rsp_ch.greatest_key};
            result_count++;
            if (got.status != ST_OK) flag_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected response %h", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.popped_key != want.popped_key) begin
                    $display("%0t: popped_key exp %h got %h", $time,
                             want.popped_key, got.popped_key);
                    error_count++;
                end
                if (got.status != want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    error_count++;
                end
                if (got.entry_total != want.entry_total) begin
                    $display("%0t: entry_total exp %0d got %0d", $time,
                             want.entry_total, got.entry_total);
                    error_count++;
                end
                if (got.least_key != want.least_key) begin
                    $display("%0t: least_key exp %h got %h", $time,
                             want.least_key, got.least_key);
                    error_count++;
                end
                if (got.greatest_key != want.greatest_key) begin
                    $display("%0t: greatest_key exp %h got %h", $time,
                             want.greatest_key, got.greatest_key);
                    error_count++;
                end
            end
        end
    end

    // keys drawn from a narrow range often, to force ties
    function automatic logic [31:0] pick_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return 32'hFFFF_FFF8 | $urandom_range(7);
            default: return $urandom;
        endcase
    endfunction

    // empty pops, key extremes, ties, an unknown code, drain both ends
    task automatic test_edges();
        send_request(REQ_POP_MIN, 32'h0);
        send_request(REQ_POP_MAX, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0);
        send_request(REQ_INSERT, 32'h0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h5555_AAAA);
        send_request(REQ_POP_MAX, 32'h0);
        send_request(REQ_POP_MAX, 32'h0);
        send_request(REQ_POP_MIN, 32'h0);
        send_request(REQ_INSERT, 32'hAAAA_5555);
        send_request(2'd3, 32'h1234_5678);
        send_request(REQ_POP_MIN, 32'h0);
        send_request(REQ_POP_MIN, 32'h0);
        send_request(REQ_POP_MAX, 32'h0);
    endtask

    task automatic test_full_heap();
        for (int i = 0; i < DEPTH + 2; i++) send_request(REQ_INSERT, pick_key());
        for (int i = 0; i < DEPTH / 2 + 1; i++) send_request(REQ_POP_MAX, 32'h0);
        for (int i = 0; i < DEPTH / 2 + 1; i++) send_request(REQ_POP_MIN, 32'h0);
    endtask

    // random mix; insert weight swings so the count sweeps empty to full
    task automatic test_random(int n);
        int bias;
        bias = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 0) bias = $urandom_range(20, 85);
            if ($urandom_range(99) < 2) send_request(2'd3, $urandom);
            else if ($urandom_range(99) < bias) send_request(REQ_INSERT, pick_key());
            else send_request($urandom_range(1) ? REQ_POP_MAX : REQ_POP_MIN, $urandom);
        end
    endtask

    initial begin
        int guard;
        error_count = 0;
        result_count = 0;
        insert_count = 0;
        pop_count = 0;
        flag_count = 0;
        shadow_count = 0;
        send_idle_pct = 27;
        recv_idle_pct = 65;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.key_in = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_edges();
        test_full_heap();
        test_random(500);
        send_idle_pct = 65;
        recv_idle_pct = 27;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(480);
        req_ch.valid <= 1'b0;

        guard = 0;
        while (pending_results.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (60) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, pending_results.size());
            error_count++;
        end

        $display("Covered %0d inserts and %0d pops (incl. unknown codes), %0d responses,",
                 insert_count, pop_count, result_count);
        $display("%0d flagged empty/full, under three handshake stall mixes.", flag_count);
        if (error_count == 0) begin
            $display("min_max_heap_priority_queue test passed");
        end else begin
            $display("min_max_heap_priority_queue test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
